[sv/bwme_pkg.sv]
// ----------------------------------------------------------------------------
// bwme_pkg: shared types and constants of the bus word Manchester encoder
// Word kinds, sync patterns, chip vector and queue sizing.
// ----------------------------------------------------------------------------
package bwme_pkg;

	localparam int ADDR_W        = 5;
	localparam int COUNT_W       = 5;
	localparam int WORD_W        = 16;
	localparam int SYNC_W        = 6;
	localparam int CHIP_W        = SYNC_W + 2 * (WORD_W + 1);
	localparam int BYTE_W        = 8;
	localparam int BYTES_PER_WORD = CHIP_W / BYTE_W;
	localparam int REM_W         = $clog2(BYTES_PER_WORD);

	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SYNC_W-1:0] SYNC_CMD_STATUS = 6'b100101;
	localparam logic [SYNC_W-1:0] SYNC_DATA       = 6'b011010;

	typedef enum logic [1:0] {
		OP_COMMAND = 2'd0,
		OP_STATUS  = 2'd1,
		OP_DATA    = 2'd2
	} opcode_t;

	typedef logic [CHIP_W-1:0] chip_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

[sv/bwme_if.sv]
// ----------------------------------------------------------------------------
// bwme_req_if / bwme_byte_if: valid-ready channels of the encoder
// Request channel carries one word request, byte channel one chip byte.
// ----------------------------------------------------------------------------
interface bwme_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  opcode;
	logic [bwme_pkg::ADDR_W-1:0] target_address;
	logic                        transmit;
	logic [4:0]                  subaddress;
	logic [bwme_pkg::COUNT_W-1:0] word_count;
	logic                        message_error;
	logic                        service_request;
	logic                        group_command;
	logic                        busy_flag;
	logic                        subsystem_flag;
	logic                        terminal_flag;
	logic [bwme_pkg::WORD_W-1:0] data_value;

	modport source (
		output valid, opcode, target_address, transmit, subaddress, word_count,
		       message_error, service_request, group_command, busy_flag,
		       subsystem_flag, terminal_flag, data_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, target_address, transmit, subaddress, word_count,
		       message_error, service_request, group_command, busy_flag,
		       subsystem_flag, terminal_flag, data_value,
		output ready
	);
endinterface

interface bwme_byte_if;
	logic                        valid;
	logic                        ready;
	logic [bwme_pkg::BYTE_W-1:0] out_byte;
	logic                        last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

[sv/bwme_front.sv]
// ----------------------------------------------------------------------------
// bwme_front: request intake and word builder
// Classifies each request, forms the 17-bit word with odd parity last and
// expands it with its sync pattern into a 40-chip vector for the queue.
// ----------------------------------------------------------------------------
module bwme_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bwme_pkg::ADDR_W-1:0]   cfg_data,
	bwme_req_if.sink                      req,
	input  bwme_pkg::queue_status_t       status,
	output logic                          push,
	output bwme_pkg::chip_word_t          push_data
);

	logic [bwme_pkg::ADDR_W-1:0] own_address_q;
	logic                        valid_s1;
	bwme_pkg::chip_word_t        chips_s1;

	logic                        accept;
	logic                        known;
	logic [bwme_pkg::WORD_W-1:0] content;
	logic [bwme_pkg::SYNC_W-1:0] sync;
	logic [bwme_pkg::WORD_W:0]   word17;
	bwme_pkg::chip_word_t        chips;

	assign push      = valid_s1 && !status.full;
	assign req.ready = !valid_s1 || !status.full;
	assign accept    = req.valid && req.ready;
	assign push_data = chips_s1;

	always_comb begin
		known   = 1'b1;
		content = '0;
		sync    = bwme_pkg::SYNC_CMD_STATUS;
		case (req.opcode)
			bwme_pkg::OP_COMMAND: begin
				content = {req.target_address, req.transmit, req.subaddress,
				           req.word_count};
			end
			bwme_pkg::OP_STATUS: begin
				content = {own_address_q, req.message_error, req.service_request,
				           3'b000, req.group_command, req.busy_flag,
				           req.subsystem_flag, 1'b0, req.terminal_flag, 1'b0};
			end
			bwme_pkg::OP_DATA: begin
				content = req.data_value;
				sync    = bwme_pkg::SYNC_DATA;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// Parity goes last for every word kind.
	assign word17 = {content, ~(^content)};

	// A one is sent high then low, a zero low then high.
	always_comb begin
		chips = '0;
		chips[bwme_pkg::CHIP_W-1 -: bwme_pkg::SYNC_W] = sync;
		for (int i = 0; i <= bwme_pkg::WORD_W; i++) begin
			chips[2*i+1 -: 2] = word17[i] ? 2'b10 : 2'b01;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_address_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= known;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chips_s1 <= chips;
		end
	end

endmodule

[sv/bwme_queue.sv]
// ----------------------------------------------------------------------------
// bwme_queue: short queue of chip vectors
// Decouples word building from byte output so each side stalls on its own.
// ----------------------------------------------------------------------------
module bwme_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  bwme_pkg::chip_word_t    push_data,
	input  logic                    pop,
	output bwme_pkg::chip_word_t    head,
	output bwme_pkg::queue_status_t status
);

	bwme_pkg::chip_word_t          mem_q [bwme_pkg::QUEUE_DEPTH];
	logic [bwme_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [bwme_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [bwme_pkg::QUEUE_CW-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign status.full  = (cnt_q == bwme_pkg::QUEUE_CW'(bwme_pkg::QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	function automatic logic [bwme_pkg::QUEUE_AW-1:0] next_ptr(
		input logic [bwme_pkg::QUEUE_AW-1:0] ptr
	);
		if (ptr == bwme_pkg::QUEUE_AW'(bwme_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[sv/bwme_back.sv]
// ----------------------------------------------------------------------------
// bwme_back: chip byte serializer
// Takes a chip vector from the queue and sends it as five bytes, first chip
// in the MSB, flagging the fifth byte.
// ----------------------------------------------------------------------------
module bwme_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bwme_pkg::chip_word_t    head,
	input  bwme_pkg::queue_status_t status,
	output logic                    pop,
	bwme_byte_if.source             tx
);

	localparam int SH_W = bwme_pkg::CHIP_W - bwme_pkg::BYTE_W;

	logic                        ovalid_q;
	logic [bwme_pkg::BYTE_W-1:0] byte_q;
	logic                        last_q;
	logic [SH_W-1:0]             sh_q;
	logic [bwme_pkg::REM_W-1:0]  rem_q;

	logic advance;

	assign advance      = !ovalid_q || tx.ready;
	assign pop          = advance && (rem_q == '0) && !status.empty;
	assign tx.valid     = ovalid_q;
	assign tx.out_byte  = byte_q;
	assign tx.last_byte = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			rem_q    <= '0;
		end else if (advance) begin
			if (rem_q != '0) begin
				ovalid_q <= 1'b1;
				rem_q    <= rem_q - 1'b1;
			end else if (!status.empty) begin
				ovalid_q <= 1'b1;
				rem_q    <= bwme_pkg::REM_W'(bwme_pkg::BYTES_PER_WORD - 1);
			end else begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (rem_q != '0) begin
				byte_q <= sh_q[SH_W-1 -: bwme_pkg::BYTE_W];
				sh_q   <= {sh_q[SH_W-bwme_pkg::BYTE_W-1:0], {bwme_pkg::BYTE_W{1'b0}}};
				last_q <= (rem_q == bwme_pkg::REM_W'(1));
			end else if (!status.empty) begin
				byte_q <= head[bwme_pkg::CHIP_W-1 -: bwme_pkg::BYTE_W];
				sh_q   <= head[SH_W-1:0];
				last_q <= 1'b0;
			end
		end
	end

endmodule

[sv/bus_word_manchester_encoder.sv]
// A request is held in the front register, then in the queue, then in the byte register.
// The byte port sends one byte per cycle while ready is high and words wait, five bytes per word.
// A two-entry queue lets new requests be taken while bytes still drain.
// A request with an undefined opcode is accepted and produces no bytes.
// Reset (arst_n low) empties the pipeline and queue and clears own_address to 0.
// ----------------------------------------------------------------------------
// bus_word_manchester_encoder: bus word Manchester encoder top level
// Front builds chip vectors, a short queue holds them, back sends the bytes.
// ----------------------------------------------------------------------------
module bus_word_manchester_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bwme_pkg::ADDR_W-1:0] cfg_data,
	bwme_req_if.sink                    req,
	bwme_byte_if.source                 tx
);

	bwme_pkg::queue_status_t status;
	bwme_pkg::chip_word_t    push_data;
	bwme_pkg::chip_word_t    head;
	logic                    push;
	logic                    pop;

	bwme_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req       (req),
		.status    (status),
		.push      (push),
		.push_data (push_data)
	);

	bwme_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	bwme_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.status (status),
		.pop    (pop),
		.tx     (tx)
	);

endmodule

[sv/bwme_checker.sv]
// ----------------------------------------------------------------------------
// bwme_checker: port-level checks of the encoder byte stream
// Watches the byte channel for sync framing, Manchester pairs, stalls and gaps.
// ----------------------------------------------------------------------------
module bwme_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] out_byte,
	input logic       last_byte
);

	logic first_q;

	// Tracks whether the next byte opens a new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (tx_valid && tx_ready) begin
			first_q <= last_byte;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(out_byte) && $stable(last_byte))
		else $error("byte changed while stalled");

	a_word_continues: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && !last_byte |=> tx_valid)
		else $error("gap inside a word");

	a_sync_first: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && first_q |->
		(out_byte[7:2] == bwme_pkg::SYNC_CMD_STATUS) ||
		(out_byte[7:2] == bwme_pkg::SYNC_DATA))
		else $error("first byte of a word lacks a sync pattern");

	a_manchester: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> (out_byte[1] != out_byte[0]) &&
		(first_q || ((out_byte[7] != out_byte[6]) && (out_byte[5] != out_byte[4]) &&
		             (out_byte[3] != out_byte[2]))))
		else $error("chip pair is not a Manchester bit");

endmodule

bind bus_word_manchester_encoder bwme_checker u_bwme_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tx_valid  (tx.valid),
	.tx_ready  (tx.ready),
	.out_byte  (tx.out_byte),
	.last_byte (tx.last_byte)
);
